>>> hw/rtl/adcmmsf_pkg.sv
// Shared types, constants and the divide-by-4095 helper of the smoothing filter.
package adcmmsf_pkg;

    localparam int WINDOW     = 16;
    localparam int IDX_W      = $clog2(WINDOW);
    localparam int CODE_W     = 12;
    localparam int SUM_W      = CODE_W + IDX_W;
    localparam int MEDIAN_IDX = WINDOW / 2;
    localparam int PROD_W     = 24;

    localparam logic [PROD_W-1:0] VOLT_MUL  = 24'd3300;
    localparam logic [PROD_W-1:0] SHIFT_MUL = 24'd990;
    localparam logic [10:0]       SHIFT_OFS = 11'd650;
    localparam logic [12:0]       FULL_CODE = 13'd4095;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SORT,
        S_CALC,
        S_MUL,
        S_DIV_V,
        S_DIV_S,
        S_OUT
    } t_state;

    typedef struct packed {
        logic              start;
        logic [IDX_W-1:0]  pos;
        logic [CODE_W-1:0] sample;
    } t_sort_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_sort_stat;

    // Exact floor(x / 4095) for x below 2^24 whose quotient stays below 4096.
    function automatic logic [CODE_W-1:0] div_full_code(input logic [PROD_W-1:0] x);
        logic [CODE_W-1:0] q;
        logic [12:0]       r;
        q = x[23:12];
        r = {1'b0, x[11:0]} + {1'b0, q};
        if (r >= FULL_CODE) begin
            q = q + 12'd1;
        end
        return q;
    endfunction

endpackage

>>> hw/rtl/adc_median_mean_smoothing_filter.sv
// Top level of the median and mean smoothing filter for 12-bit converter samples.
//
// The input channel (i_valid, o_ready) carries a command bit and a 12-bit sample.
// A seed beat (i_cmd high) loads the sample into the smoothed level and gives no
// result. A filter beat inserts the sample into a sorted window of sixteen
// entries; the insertion compares and shifts one entry per cycle, so a filter
// beat keeps o_ready low until its insertion is done, with up to fifteen shifts
// on the last sample. On the sixteenth sample the block computes median, mean,
// blend and level, then two constant products and their division by 4095
// through one shared divider, in the states S_CALC, S_MUL, S_DIV_V, S_DIV_S and
// S_OUT, and presents one result beat on the output channel (o_valid, i_ready).
// A new sample is taken only once the previous insertion is done, and after the
// last sample of a window only once its result is loaded into the output register.
// The result sits in an output register; the next window's samples are taken
// while it waits, and only a following window end stalls until i_ready.
// Reset clears the level, fill count, sum and all handshake state; the window
// store itself is not cleared.
module adc_median_mean_smoothing_filter
    import adcmmsf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_cmd,
    input  logic [CODE_W-1:0] i_sample,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [CODE_W-1:0] o_median_code,
    output logic [CODE_W-1:0] o_mean_code,
    output logic [CODE_W-1:0] o_level_code,
    output logic [CODE_W-1:0] o_voltage_mv,
    output logic [10:0]       o_shifted_mv
);

    t_state            r_state, n_state;
    logic [IDX_W-1:0]  r_fill, n_fill;
    logic [SUM_W-1:0]  r_sum, n_sum;
    logic [CODE_W-1:0] r_level, n_level;
    logic [CODE_W-1:0] r_med, n_med;
    logic [CODE_W-1:0] r_mean, n_mean;
    logic [PROD_W-1:0] r_prod, n_prod;
    logic [CODE_W-1:0] r_volt, n_volt;
    logic [10:0]       r_shift, n_shift;
    logic              r_out_valid, n_out_valid;
    logic [CODE_W-1:0] r_out_med, r_out_mean, r_out_level, r_out_volt;
    logic [10:0]       r_out_shift;
    logic              out_load;

    t_sort_req         sort_req;
    t_sort_stat        sort_stat;
    logic [CODE_W-1:0] sort_median;

    logic [13:0]       blend_sum;
    logic [15:0]       level_sum;
    logic [CODE_W-1:0] div_q;

    adcmmsf_sort u_sort (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (sort_req),
        .o_stat   (sort_stat),
        .o_median (sort_median)
    );

    assign blend_sum = {1'b0, sort_median, 1'b0} + {2'b0, sort_median}
                     + {2'b0, r_sum[SUM_W-1:IDX_W]};
    assign level_sum = {r_level, 4'b0} - {4'b0, r_level} + {4'b0, blend_sum[13:2]};
    assign div_q     = div_full_code(r_prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_sum       <= '0;
            r_level     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_sum       <= n_sum;
            r_level     <= n_level;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_med   <= n_med;
        r_mean  <= n_mean;
        r_prod  <= n_prod;
        r_volt  <= n_volt;
        r_shift <= n_shift;
        if (out_load) begin
            r_out_med   <= r_med;
            r_out_mean  <= r_mean;
            r_out_level <= r_level;
            r_out_volt  <= r_volt;
            r_out_shift <= r_shift;
        end
    end

    always_comb begin
        n_state         = r_state;
        n_fill          = r_fill;
        n_sum           = r_sum;
        n_level         = r_level;
        n_med           = r_med;
        n_mean          = r_mean;
        n_prod          = r_prod;
        n_volt          = r_volt;
        n_shift         = r_shift;
        n_out_valid     = r_out_valid && !i_ready;
        out_load        = 1'b0;
        o_ready         = 1'b0;
        sort_req.start  = 1'b0;
        sort_req.pos    = r_fill;
        sort_req.sample = i_sample;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    if (i_cmd) begin
                        n_level = i_sample;
                    end else begin
                        sort_req.start = 1'b1;
                        n_sum          = r_sum + {{IDX_W{1'b0}}, i_sample};
                        n_state        = S_SORT;
                    end
                end
            end
            S_SORT: begin
                if (sort_stat.done) begin
                    if (r_fill == IDX_W'(WINDOW - 1)) begin
                        n_state = S_CALC;
                    end else begin
                        n_fill  = r_fill + IDX_W'(1);
                        n_state = S_IDLE;
                    end
                end
            end
            S_CALC: begin
                n_med   = sort_median;
                n_mean  = r_sum[SUM_W-1:IDX_W];
                n_level = level_sum[15:4];
                n_fill  = '0;
                n_sum   = '0;
                n_state = S_MUL;
            end
            S_MUL: begin
                n_prod  = {{(PROD_W-CODE_W){1'b0}}, r_level} * VOLT_MUL;
                n_state = S_DIV_V;
            end
            S_DIV_V: begin
                n_volt  = div_q;
                n_prod  = {{(PROD_W-CODE_W){1'b0}}, r_level} * SHIFT_MUL;
                n_state = S_DIV_S;
            end
            S_DIV_S: begin
                n_shift = div_q[10:0] + SHIFT_OFS;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || i_ready) begin
                    out_load    = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_valid       = r_out_valid;
    assign o_median_code = r_out_med;
    assign o_mean_code   = r_out_mean;
    assign o_level_code  = r_out_level;
    assign o_voltage_mv  = r_out_volt;
    assign o_shifted_mv  = r_out_shift;

    a_filter_beat_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && !i_cmd) |=> !o_ready)
        else $error("Filter beat accepted without leaving the ready state.");

    a_sort_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sort_req.start |-> !sort_stat.busy)
        else $error("Insertion started while the previous one is running.");

    a_volt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_voltage_mv <= 12'd3300 && o_shifted_mv >= 11'd650
                     && o_shifted_mv <= 11'd1640))
        else $error("Scaled voltage outside its range.");

endmodule

>>> hw/rtl/adcmmsf_sort.sv
// Window store kept in ascending order by insertion, one compare-and-shift per cycle.
module adcmmsf_sort
    import adcmmsf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_sort_req         i_req,
    output t_sort_stat        o_stat,
    output logic [CODE_W-1:0] o_median
);

    logic [CODE_W-1:0] r_win [WINDOW];
    logic [IDX_W-1:0]  r_idx;
    logic [CODE_W-1:0] r_val;
    logic              r_busy;
    logic              r_done;
    logic [CODE_W-1:0] rd_data;
    logic              shift_up;

    assign rd_data  = r_win[r_idx - IDX_W'(1)];
    assign shift_up = (r_idx != '0) && (rd_data > r_val);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (r_busy) begin
                if (!shift_up) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end else if (i_req.start) begin
                r_busy <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            if (shift_up) begin
                r_win[r_idx] <= rd_data;
                r_idx        <= r_idx - IDX_W'(1);
            end else begin
                r_win[r_idx] <= r_val;
            end
        end else if (i_req.start) begin
            r_idx <= i_req.pos;
            r_val <= i_req.sample;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_median    = r_win[MEDIAN_IDX];

endmodule
